// File: rtl/core/pcri_pkg.sv
// ----------------------------------------------------------------------------
// Current ramp interlock package
// Shared constants, register indexes and types for the supply current ramp
// interlock.
// ----------------------------------------------------------------------------
package pcri_pkg;

	localparam int TICK_W     = 8;
	localparam int LEVEL_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LEVEL_W;
	localparam int PLANT_W    = 3;
	localparam int RDF_W      = 10;
	localparam int SDF_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_INTERVAL = 3'd0,
		REG_RAMP_STEP     = 3'd1,
		REG_TRIP_DELAY    = 3'd2,
		REG_H2_ON_LEVEL   = 3'd3,
		REG_H2_OFF_LEVEL  = 3'd4,
		REG_FLOOR_LEVEL   = 3'd5
	} cfg_reg_t;

	localparam logic [TICK_W-1:0]  RST_RAMP_INTERVAL = 8'd90;
	localparam logic [TICK_W-1:0]  RST_RAMP_STEP     = 8'd32;
	localparam logic [TICK_W-1:0]  RST_TRIP_DELAY    = 8'd20;
	localparam logic [LEVEL_W-1:0] RST_H2_ON_LEVEL   = 16'd160;
	localparam logic [LEVEL_W-1:0] RST_H2_OFF_LEVEL  = 16'd16;
	localparam logic [LEVEL_W-1:0] RST_FLOOR_LEVEL   = 16'd8;

	localparam logic [PLANT_W-1:0] PS_STANDBY = 3'd1;
	localparam logic [PLANT_W-1:0] PS_READY   = 3'd2;
	localparam logic [PLANT_W-1:0] PS_CHECK   = 3'd3;
	localparam logic [PLANT_W-1:0] PS_POWER   = 3'd4;

	localparam int XF_STANDBY = 0;
	localparam int XF_READY   = 1;
	localparam int XF_HOLD    = 2;
	localparam int XF_INST    = 3;
	localparam int XF_CFAULT  = 4;
	localparam int XF_W       = 5;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/core/pcri_if.sv
// ----------------------------------------------------------------------------
// Current ramp interlock channels
// Valid/ready channels for the control tick and the per-tick result.
// ----------------------------------------------------------------------------
interface pcri_tick_if import pcri_pkg::*; #(
	parameter int NODE_COUNT   = 27,
	parameter int CURRENT_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [CURRENT_BITS-1:0] current_request;
	logic [NODE_COUNT-1:0]   node_mask;
	logic [PLANT_W-1:0]      plant_state;
	logic                    manual_test;
	logic                    master_start;
	logic                    stack_power_cmd;
	logic [RDF_W-1:0]        rampdown_faults;
	logic [SDF_W-1:0]        shutdown_faults;

	modport source (
		output valid, current_request, node_mask, plant_state, manual_test,
		       master_start, stack_power_cmd, rampdown_faults, shutdown_faults,
		input  ready
	);
	modport sink (
		input  valid, current_request, node_mask, plant_state, manual_test,
		       master_start, stack_power_cmd, rampdown_faults, shutdown_faults,
		output ready
	);
endinterface

interface pcri_result_if import pcri_pkg::*; #(
	parameter int NODE_COUNT   = 27,
	parameter int CURRENT_BITS = 16
);
	localparam int UNIT_W = $clog2(NODE_COUNT + 1);

	logic                    valid;
	logic                    ready;
	logic [CURRENT_BITS-1:0] unit_setpoint;
	logic [CURRENT_BITS-1:0] total_setpoint;
	logic [CURRENT_BITS-1:0] share_limit;
	logic                    h2_request;
	logic                    go_standby;
	logic                    go_ready;
	logic                    hold_stack_power;
	logic                    instant_shutdown;
	logic                    current_fault;
	logic [UNIT_W-1:0]       units_present;

	modport source (
		output valid, unit_setpoint, total_setpoint, share_limit, h2_request,
		       go_standby, go_ready, hold_stack_power, instant_shutdown,
		       current_fault, units_present,
		input  ready
	);
	modport sink (
		input  valid, unit_setpoint, total_setpoint, share_limit, h2_request,
		       go_standby, go_ready, hold_stack_power, instant_shutdown,
		       current_fault, units_present,
		output ready
	);
endinterface

// File: rtl/core/pcri_div.sv
// ----------------------------------------------------------------------------
// Current ramp interlock divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcri_div import pcri_pkg::*; #(
	parameter int DVD_W = 16,
	parameter int DSR_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output div_stat_t        stat
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule

// File: rtl/core/psu_current_ramp_interlock_unit.sv
// ----------------------------------------------------------------------------
// Supply current ramp interlock
// Per-tick hydrogen request hysteresis, per-unit setpoint ramp with share
// clamp, ramp-down floor and shutdown-fault trip delay.
// ----------------------------------------------------------------------------
// Each tick is accepted in S_IDLE, then its unit mask is counted four bits
// per cycle in S_COUNT, and the share of the request per present unit comes
// from a restoring divider in S_DIV that yields one quotient bit per cycle,
// before S_UPDATE writes the result register. A new tick is taken once the
// previous one has been written to the result register, even while that
// result still waits to be taken.
module psu_current_ramp_interlock_unit import pcri_pkg::*; #(
	parameter int NODE_COUNT   = 27,
	parameter int CURRENT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pcri_tick_if.sink             tick,
	pcri_result_if.source         result
);
	localparam int CB     = CURRENT_BITS;
	localparam int UNIT_W = $clog2(NODE_COUNT + 1);
	localparam int NIB_W  = 4;
	localparam int SUM_W  = CB + 1;
	localparam int CMP_W  = (CB > LEVEL_W) ? CB : LEVEL_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COUNT,
		S_DIV,
		S_UPDATE
	} state_t;

	function automatic logic [2:0] pop4(input logic [NIB_W-1:0] v);
		return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
	endfunction

	state_t               state_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 commit;
	logic                 div_start;
	div_stat_t            div_stat;
	logic [CB-1:0]        quo;

	logic [TICK_W-1:0]    interval_q;
	logic [TICK_W-1:0]    step_q;
	logic [TICK_W-1:0]    trip_delay_q;
	logic [LEVEL_W-1:0]   h2_on_q;
	logic [LEVEL_W-1:0]   h2_off_q;
	logic [LEVEL_W-1:0]   floor_q;

	logic [CB-1:0]        req_q;
	logic [NODE_COUNT-1:0] mask_q;
	logic [UNIT_W-1:0]    count_q;
	logic [PLANT_W-1:0]   pstate_q;
	logic                 manual_q;
	logic                 master_q;
	logic                 stk_q;
	logic                 rf_q;
	logic                 sf_q;

	logic [CB-1:0]        unit_q;
	logic [CB-1:0]        total_q;
	logic [CB-1:0]        share_q;
	logic [TICK_W-1:0]    up_q;
	logic [TICK_W-1:0]    down_q;
	logic [TICK_W-1:0]    trip_q;
	logic                 h2_q;
	logic [XF_W-1:0]      exit_q;
	logic [UNIT_W-1:0]    units_out_q;

	logic [CB-1:0]        unit_n;
	logic [CB-1:0]        total_n;
	logic [CB-1:0]        share_n;
	logic [TICK_W-1:0]    up_n;
	logic [TICK_W-1:0]    down_n;
	logic [TICK_W-1:0]    trip_n;
	logic                 h2_n;
	logic [XF_W-1:0]      exit_n;

	assign accept    = tick.valid && tick.ready;
	assign tick.ready = state_q == S_IDLE;
	assign commit    = (state_q == S_UPDATE) && (!out_valid_q || result.ready);
	assign div_start = (state_q == S_COUNT) && (mask_q == '0);

	pcri_div #(
		.DVD_W (CB),
		.DSR_W (UNIT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req_q),
		.divisor  (count_q),
		.quotient (quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= RST_RAMP_INTERVAL;
			step_q       <= RST_RAMP_STEP;
			trip_delay_q <= RST_TRIP_DELAY;
			h2_on_q      <= RST_H2_ON_LEVEL;
			h2_off_q     <= RST_H2_OFF_LEVEL;
			floor_q      <= RST_FLOOR_LEVEL;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RAMP_INTERVAL: interval_q   <= cfg_wdata[TICK_W-1:0];
				REG_RAMP_STEP:     step_q       <= cfg_wdata[TICK_W-1:0];
				REG_TRIP_DELAY:    trip_delay_q <= cfg_wdata[TICK_W-1:0];
				REG_H2_ON_LEVEL:   h2_on_q      <= cfg_wdata[LEVEL_W-1:0];
				REG_H2_OFF_LEVEL:  h2_off_q     <= cfg_wdata[LEVEL_W-1:0];
				REG_FLOOR_LEVEL:   floor_q      <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= tick.current_request;
			mask_q   <= tick.node_mask;
			count_q  <= '0;
			pstate_q <= tick.plant_state;
			manual_q <= tick.manual_test;
			master_q <= tick.master_start;
			stk_q    <= tick.stack_power_cmd;
			rf_q     <= |tick.rampdown_faults;
			sf_q     <= |tick.shutdown_faults;
		end else if ((state_q == S_COUNT) && (mask_q != '0)) begin
			mask_q  <= mask_q >> NIB_W;
			count_q <= count_q + UNIT_W'(pop4(NIB_W'(mask_q)));
		end
	end

	always_comb begin
		logic              idle_state;
		logic              run_state;
		logic              healthy;
		logic [TICK_W-1:0] tick_inc;
		logic [SUM_W-1:0]  up_sum;

		unit_n  = unit_q;
		total_n = total_q;
		share_n = share_q;
		up_n    = up_q;
		down_n  = down_q;
		trip_n  = trip_q;
		exit_n  = exit_q;
		h2_n    = h2_q;
		tick_inc = '0;
		up_sum   = '0;

		if (CMP_W'(req_q) >= CMP_W'(h2_on_q)) begin
			h2_n = 1'b1;
		end else if (CMP_W'(req_q) < CMP_W'(h2_off_q)) begin
			h2_n = 1'b0;
		end

		idle_state = ((pstate_q == PS_STANDBY) || (pstate_q == PS_READY) ||
			(pstate_q == PS_CHECK)) && !manual_q;
		run_state  = (pstate_q == PS_POWER) || manual_q;
		healthy    = h2_n && master_q && stk_q && !rf_q && !sf_q;

		if (count_q == '0) begin
			unit_n = '0;
		end else if (idle_state) begin
			total_n = '0;
		end else if (run_state) begin
			if (healthy) begin
				down_n   = '0;
				trip_n   = '0;
				exit_n   = '0;
				tick_inc = up_q + 1'b1;
				total_n  = req_q;
				share_n  = quo;
				up_n     = tick_inc;
				if (tick_inc >= interval_q) begin
					up_sum = SUM_W'(unit_q) + SUM_W'(step_q);
					unit_n = up_sum[CB] ? {CB{1'b1}} : up_sum[CB-1:0];
					up_n   = '0;
				end
				if (unit_n >= quo) begin
					unit_n = quo;
				end
			end else begin
				if (!stk_q || !h2_n || !master_q || rf_q) begin
					up_n   = '0;
					exit_n[XF_INST]   = 1'b0;
					exit_n[XF_CFAULT] = 1'b1;
					total_n  = req_q;
					share_n  = quo;
					tick_inc = down_q + 1'b1;
					down_n   = tick_inc;
					if (tick_inc >= interval_q) begin
						unit_n = (unit_q > CB'(step_q)) ? unit_q - CB'(step_q) : '0;
						down_n = '0;
					end
					if (CMP_W'(unit_n) <= CMP_W'(floor_q)) begin
						unit_n  = '0;
						share_n = '0;
						if (!master_q) begin
							exit_n[XF_STANDBY] = 1'b1;
							exit_n[XF_HOLD]    = 1'b0;
						end else if (!h2_n) begin
							exit_n[XF_READY]   = 1'b1;
							exit_n[XF_STANDBY] = 1'b0;
							exit_n[XF_HOLD]    = 1'b0;
						end else begin
							exit_n[XF_READY]   = 1'b0;
							exit_n[XF_STANDBY] = 1'b0;
							exit_n[XF_HOLD]    = 1'b1;
						end
					end
				end
				if (sf_q) begin
					down_n = '0;
					up_n   = '0;
					exit_n[XF_CFAULT]  = 1'b1;
					exit_n[XF_STANDBY] = 1'b0;
					exit_n[XF_HOLD]    = 1'b0;
					trip_n = (trip_q != {TICK_W{1'b1}}) ? trip_q + 1'b1 : trip_q;
					if (trip_n >= trip_delay_q) begin
						trip_n = trip_delay_q;
						exit_n[XF_INST] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			unit_q      <= '0;
			total_q     <= '0;
			share_q     <= '0;
			up_q        <= '0;
			down_q      <= '0;
			trip_q      <= '0;
			h2_q        <= 1'b0;
			exit_q      <= '0;
			units_out_q <= '0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				unit_q      <= unit_n;
				total_q     <= total_n;
				share_q     <= share_n;
				up_q        <= up_n;
				down_q      <= down_n;
				trip_q      <= trip_n;
				h2_q        <= h2_n;
				exit_q      <= exit_n;
				units_out_q <= count_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid            = out_valid_q;
	assign result.unit_setpoint    = unit_q;
	assign result.total_setpoint   = total_q;
	assign result.share_limit      = share_q;
	assign result.h2_request       = h2_q;
	assign result.go_standby       = exit_q[XF_STANDBY];
	assign result.go_ready         = exit_q[XF_READY];
	assign result.hold_stack_power = exit_q[XF_HOLD];
	assign result.instant_shutdown = exit_q[XF_INST];
	assign result.current_fault    = exit_q[XF_CFAULT];
	assign result.units_present    = units_out_q;

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("Divider finished outside the divide phase.");

	a_div_busy_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == S_DIV))
		else $error("Divider running outside the divide phase.");

	a_no_units_zero_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (units_out_q == '0)) |-> (unit_q == '0))
		else $error("Setpoint nonzero with no unit present.");

	a_trip_implies_fault: assert property (@(posedge clk) disable iff (!arst_n)
		exit_q[XF_INST] |-> exit_q[XF_CFAULT])
		else $error("Instant shutdown without current fault.");

endmodule
